FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the credit key table.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CKT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("credit key table: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("credit key table: assertion failed");

`endif

FILE: rtl/ckt_pkg.sv
// Package for the credit key table: word types, command and status codes.
// No dependencies; used by the cell, the top level and the testbench.
package ckt_pkg;

    localparam int CKT_CMD_W    = 2;
    localparam int CKT_KEY_W    = 56;
    localparam int CKT_CRED_W   = 16;
    localparam int CKT_STATUS_W = 3;
    localparam int CKT_INDEX_W  = 4;
    localparam int CKT_COUNT_W  = 5;

    localparam logic [CKT_CRED_W-1:0] CKT_CRED_RESET = 16'd10;

    // Command codes
    localparam logic [CKT_CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CKT_CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CKT_CMD_W-1:0] CMD_CHECK  = 2'd2;
    localparam logic [CKT_CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // Status codes
    localparam logic [CKT_STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [CKT_STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [CKT_STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [CKT_STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [CKT_STATUS_W-1:0] ST_NOCREDIT = 3'd4;

    typedef struct packed {
        logic [CKT_CMD_W-1:0] command;
        logic [CKT_KEY_W-1:0] card_key;
    } t_ckt_req;

    typedef struct packed {
        logic [CKT_STATUS_W-1:0] status;
        logic [CKT_INDEX_W-1:0]  entry_index;
        logic [CKT_COUNT_W-1:0]  entry_count;
    } t_ckt_rsp;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                  cmp_en;
        logic [CKT_KEY_W-1:0]  key;
        logic [CKT_CRED_W-1:0] credit;
    } t_ckt_cell_ctrl;

endpackage

FILE: rtl/ckt_stream_if.sv
// Valid/ready channel carrying one word of type T.
// Depends on nothing; the payload type is set where the channel is declared.
interface ckt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ckt_cell.sv
// One entry of the key table: key and credit registers, key compare, shift-in.
// Depends on ckt_pkg for the broadcast control struct.
module ckt_cell #(
    parameter int KW = 56
) (
    input  logic                           i_clk,
    input  ckt_pkg::t_ckt_cell_ctrl        i_ctrl,
    input  logic                           i_valid,
    input  logic                           i_load,
    input  logic                           i_shift,
    input  logic [KW-1:0]                  i_nb_key,
    input  logic [ckt_pkg::CKT_CRED_W-1:0] i_nb_credit,
    output logic [KW-1:0]                  o_key,
    output logic [ckt_pkg::CKT_CRED_W-1:0] o_credit,
    output logic                           o_match
);
    import ckt_pkg::*;

    logic [KW-1:0]         r_key;
    logic [CKT_CRED_W-1:0] r_credit;
    logic                  r_match;

    // Entry contents: load a new key, or take the upper neighbour's entry
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key    <= i_ctrl.key[KW-1:0];
            r_credit <= i_ctrl.credit;
        end else if (i_shift) begin
            r_key    <= i_nb_key;
            r_credit <= i_nb_credit;
        end
    end

    // Registered compare; only live entries may hit
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= i_valid && (r_key == i_ctrl.key[KW-1:0]);
        end
    end

    assign o_key    = r_key;
    assign o_credit = r_credit;
    assign o_match  = r_match;

endmodule

FILE: rtl/credit_key_table_unit.sv
// Top level of the credit key table: controller, row of entry cells, result register.
// Depends on ckt_pkg, ckt_stream_if, ckt_cell and assert_macros.svh.
//
// Usage
//   i_req (sink): one word per command (add, remove, check, clear) with a card key.
//   o_rsp (source): one word per command with status, entry index and entry count.
//   i_cfg (sink): 16-bit initial credit value, always ready; write it only while
//   the block is idle. Reset value is 10.
// Timing
//   A command goes through accept, compare in every cell at once, resolve the
//   single hit (keys are unique) by an OR over the row, then apply and load the
//   result register. The next command is taken in the cycle after the apply, so
//   commands do not overlap: a new one is taken only once the last is applied.
//   The row of cells shares one key/hit broadcast.
//   Remove closes the gap in the apply step: the hit cell and every cell above
//   it take their upper neighbour's entry.
// Reset and stall
//   Synchronous active-low reset empties the table and drops any pending result.
//   A stalled receiver holds the result; a command already taken waits in its
//   apply step until the result register is free, and no new command is taken.
`include "assert_macros.svh"

module credit_key_table_unit #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 56
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ckt_stream_if.sink   i_req,
    ckt_stream_if.source o_rsp,
    ckt_stream_if.sink   i_cfg
);
    import ckt_pkg::*;

    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SKW = (KEY_BITS < CKT_KEY_W) ? KEY_BITS : CKT_KEY_W;

    // Controller states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_COMPARE = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;
    localparam logic [1:0] S_APPLY   = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CKT_CMD_W-1:0]  r_cmd;
    logic [SKW-1:0]        r_key;
    logic [CW-1:0]         r_count, n_count;
    logic [CKT_CRED_W-1:0] r_init_cred;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_pos, n_pos;
    logic                  r_cred_zero;
    logic [CKT_CRED_W-1:0] n_cred;
    logic                  r_rsp_valid;
    t_ckt_rsp              r_rsp, n_rsp;

    logic                  w_accept;
    logic                  w_commit;
    logic                  w_full;
    logic                  w_do_add;
    logic                  w_do_remove;
    t_ckt_cell_ctrl        w_ctrl;

    logic [SKW-1:0]        w_key    [ENTRIES+1];
    logic [CKT_CRED_W-1:0] w_credit [ENTRIES+1];
    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES-1:0]    w_valid;
    logic [ENTRIES-1:0]    w_load;
    logic [ENTRIES-1:0]    w_shift;

    // Handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_commit    = (r_state == S_APPLY) && (!r_rsp_valid || o_rsp.ready);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cred <= CKT_CRED_RESET;
        end else if (i_cfg.valid) begin
            r_init_cred <= i_cfg.data;
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.data.command;
            r_key <= i_req.data.card_key[SKW-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_accept) n_state = S_COMPARE;
            S_COMPARE: n_state = S_RESOLVE;
            S_RESOLVE: n_state = S_APPLY;
            S_APPLY:   if (w_commit) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Broadcast to the row
    assign w_ctrl.cmp_en = (r_state == S_COMPARE);
    assign w_ctrl.key    = CKT_KEY_W'(r_key);
    assign w_ctrl.credit = r_init_cred;

    // Per-cell selects
    assign w_full      = (r_count == CW'(ENTRIES));
    assign w_do_add    = w_commit && (r_cmd == CMD_ADD) && !w_full && !r_found;
    assign w_do_remove = w_commit && (r_cmd == CMD_REMOVE) && r_found;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_valid[i] = (CW'(i) < r_count);
            w_load[i]  = w_do_add && (CW'(i) == r_count);
            w_shift[i] = w_do_remove && (IW'(i) >= r_pos);
        end
    end

    // Row of cells; the top one shifts in an empty entry
    assign w_key[ENTRIES]    = '0;
    assign w_credit[ENTRIES] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ckt_cell #(
            .KW (SKW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_valid     (w_valid[g]),
            .i_load      (w_load[g]),
            .i_shift     (w_shift[g]),
            .i_nb_key    (w_key[g+1]),
            .i_nb_credit (w_credit[g+1]),
            .o_key       (w_key[g]),
            .o_credit    (w_credit[g]),
            .o_match     (w_match[g])
        );
    end

    // Resolve the hit: at most one cell matches, so an OR gathers it
    always_comb begin
        n_found = 1'b0;
        n_pos   = '0;
        n_cred  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                n_found = 1'b1;
                n_pos   = n_pos | IW'(i);
                n_cred  = n_cred | w_credit[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESOLVE) begin
            r_found     <= n_found;
            r_pos       <= n_pos;
            r_cred_zero <= (n_cred == '0);
        end
    end

    // Apply: status and new count
    always_comb begin
        n_count           = r_count;
        n_rsp.status      = ST_OK;
        n_rsp.entry_index = '0;
        case (r_cmd)
            CMD_ADD: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else if (r_found) begin
                    n_rsp.status = ST_DUP;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (!r_found) begin
                    n_rsp.status = ST_NOTFOUND;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_CHECK: begin
                if (!r_found) begin
                    n_rsp.status = ST_NOTFOUND;
                end else if (r_cred_zero) begin
                    n_rsp.status = ST_NOCREDIT;
                end else begin
                    n_rsp.entry_index = CKT_INDEX_W'(r_pos);
                end
            end
            CMD_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
        n_rsp.entry_count = CKT_COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_commit) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_commit) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // Checks
    `CKT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES))
    `CKT_ASSERT_SAME(a_unique_hit, i_clk, i_rst_n, r_state == S_RESOLVE, $onehot0(w_match))
    `CKT_ASSERT_SAME(a_rsp_from_apply, i_clk, i_rst_n, $rose(r_rsp_valid),
                     $past(r_state) == S_APPLY)
    `CKT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == S_COMPARE)

endmodule

FILE: sim/tb_credit_key_table_unit.sv
// Testbench for credit_key_table_unit: drives add/remove/check/clear words and
// checks every reply word against a table model kept in a small scoreboard class.
// Depends on ckt_pkg, ckt_stream_if and the credit_key_table_unit RTL.
`timescale 1ns / 100ps

module tb_credit_key_table_unit;
    import ckt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 20;
    localparam logic [CKT_KEY_W-1:0] FILL_BASE = 56'h3C_0000_0000_0000;

    // Table model and queue of awaited reply words
    class credit_table_scoreboard;
        logic [CKT_KEY_W-1:0]  keys    [TABLE_DEPTH];
        logic [CKT_CRED_W-1:0] credits [TABLE_DEPTH];
        int                    count;
        logic [CKT_CRED_W-1:0] grant;
        t_ckt_rsp              awaited [$];
        int unsigned           failures;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                keys[i]    = '0;
                credits[i] = '0;
            end
            count    = 0;
            grant    = CKT_CRED_RESET;
            failures = 0;
        endfunction

        function void set_credits(logic [CKT_CRED_W-1:0] value);
            grant = value;
        endfunction

        // first live entry holding the key, TABLE_DEPTH when absent
        function int lookup(logic [CKT_KEY_W-1:0] key);
            for (int i = 0; i < count; i++) begin
                if (keys[i] == key) return i;
            end
            return TABLE_DEPTH;
        endfunction

        // Update the model for an accepted command word, queue its reply
        function void apply_command(t_ckt_req w);
            t_ckt_rsp r;
            int       pos;
            r   = '0;
            pos = lookup(w.card_key);
            case (w.command)
                CMD_ADD: begin
                    // full is tested ahead of duplicate
                    if (count >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (pos < TABLE_DEPTH) begin
                        r.status = ST_DUP;
                    end else begin
                        keys[count]    = w.card_key;
                        credits[count] = grant;
                        count++;
                    end
                end
                CMD_REMOVE: begin
                    if (pos >= TABLE_DEPTH) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        // close the gap, entries above the count go to zero
                        for (int j = pos; j < count - 1; j++) begin
                            keys[j]    = keys[j + 1];
                            credits[j] = credits[j + 1];
                        end
                        count--;
                        keys[count]    = '0;
                        credits[count] = '0;
                    end
                end
                CMD_CHECK: begin
                    if (pos >= TABLE_DEPTH) begin
                        r.status = ST_NOTFOUND;
                    end else if (credits[pos] == '0) begin
                        r.status = ST_NOCREDIT;
                    end else begin
                        r.entry_index = pos[CKT_INDEX_W-1:0];
                    end
                end
                default: begin
                    for (int j = 0; j < TABLE_DEPTH; j++) begin
                        keys[j]    = '0;
                        credits[j] = '0;
                    end
                    count = 0;
                end
            endcase
            r.entry_count = count[CKT_COUNT_W-1:0];
            awaited.push_back(r);
        endfunction

        // Compare a reply word with the oldest awaited one
        function void check_reply(t_ckt_rsp got);
            t_ckt_rsp exp_w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected reply: status %0d index %0d count %0d",
                         $time, got.status, got.entry_index, got.entry_count);
                failures++;
                return;
            end
            exp_w = awaited.pop_front();
            if (got.status !== exp_w.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_w.status, got.status);
                failures++;
            end
            if (got.entry_index !== exp_w.entry_index) begin
                $display("%0t: entry_index expected %0d actual %0d",
                         $time, exp_w.entry_index, got.entry_index);
                failures++;
            end
            if (got.entry_count !== exp_w.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, exp_w.entry_count, got.entry_count);
                failures++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   stall_left;

    logic [CKT_KEY_W-1:0]   key_pool [POOL_SIZE];
    credit_table_scoreboard sb;

    ckt_stream_if #(.T(t_ckt_req))                 req_if ();
    ckt_stream_if #(.T(t_ckt_rsp))                 rsp_if ();
    ckt_stream_if #(.T(logic [CKT_CRED_W-1:0]))    cfg_if ();

    credit_key_table_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Known levels from time zero
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        quiet         = 1'b0;
        stall_left    = 0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        rsp_if.ready  = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Receiver: random stall bursts, none in the quiet stretch
    always @(negedge i_clk) begin
        if (quiet) begin
            stall_left = 0;
            rsp_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Reply monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_reply(rsp_if.data);
    end

    // Watchdog
    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

    // One command word; valid is left high after the handshake
    task automatic send_command(input logic [CKT_CMD_W-1:0] cmd,
                                input logic [CKT_KEY_W-1:0] key);
        t_ckt_req w;
        w.command  = cmd;
        w.card_key = key;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        do @(posedge i_clk); while (!req_if.ready);
        sb.apply_command(w);
    endtask

    // Drop valid and wait until every reply word is in
    task automatic drain_replies();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_credits(input logic [CKT_CRED_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_credits(value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly pooled keys so adds, hits and a full table all come up
    task automatic run_random(input int n);
        logic [CKT_CMD_W-1:0] cmd;
        logic [CKT_KEY_W-1:0] key;
        logic [63:0]          raw;
        int                   pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) cmd = CMD_ADD;
            else if (pick < 65) cmd = CMD_REMOVE;
            else if (pick < 97) cmd = CMD_CHECK;
            else cmd = CMD_CLEAR;
            raw = {$urandom(), $urandom()};
            if ($urandom_range(0, 9) == 0) key = raw[CKT_KEY_W-1:0];
            else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_command(cmd, key);
        end
    endtask

    initial begin
        logic [CKT_CRED_W-1:0] credit_plan [6];
        logic [63:0]           raw;
        sb = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            raw = {$urandom(), $urandom()};
            key_pool[i] = raw[CKT_KEY_W-1:0];
        end
        credit_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, CKT_CRED_RESET};
        credit_plan[3] = CKT_CRED_W'($urandom_range(2, 65534));
        credit_plan[4] = CKT_CRED_W'($urandom_range(2, 65534));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default credits: zero key, duplicate, a hit, a miss, widest key, clear
        send_command(CMD_ADD, '0);
        send_command(CMD_ADD, '0);
        send_command(CMD_CHECK, '0);
        send_command(CMD_REMOVE, 56'h5);
        send_command(CMD_ADD, '1);
        send_command(CMD_CHECK, '1);
        send_command(CMD_CLEAR, '1);
        drain_replies();

        // zero credits: a present key is refused
        write_credits(16'd0);
        send_command(CMD_ADD, 56'h5A);
        send_command(CMD_CHECK, 56'h5A);
        drain_replies();

        // fill the table, refuse when full (also for a present key), compaction
        write_credits(16'hFFFF);
        for (int i = 1; i < TABLE_DEPTH; i++) send_command(CMD_ADD, FILL_BASE | CKT_KEY_W'(i));
        send_command(CMD_ADD, FILL_BASE | 56'd16);
        send_command(CMD_ADD, 56'h5A);
        send_command(CMD_REMOVE, 56'h5A);
        send_command(CMD_CHECK, FILL_BASE | 56'd6);
        send_command(CMD_REMOVE, FILL_BASE | 56'd15);
        send_command(CMD_CLEAR, '0);

        // random phases, one credit setting each; last phase without idling
        for (int p = 0; p < 6; p++) begin
            drain_replies();
            write_credits(credit_plan[p]);
            quiet = (p == 5);
            run_random(125);
        end
        drain_replies();
        repeat (12) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
